### rtl/core/vgbd_pkg.sv
// ============================================================================
// Voxel grid boundary distance: shared package
// Field widths, operation and register codes, and the beat types of the block.
// ============================================================================
package vgbd_pkg;

    localparam int COORD_W  = 32;   // position and plane coordinates, Q16.16
    localparam int DIR_W    = 16;   // direction cosines, Q2.14
    localparam int DMAG_W   = 16;   // magnitude of a direction cosine
    localparam int DIST_W   = 31;   // unsigned Q15.16 distances
    localparam int REGION_W = 19;
    localparam int CNT_W    = 7;    // voxel counts and voxel indices
    localparam int BIDX_W   = 7;
    localparam int STRIDE_W = 2 * CNT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic signed [COORD_W:0] t_diff;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOXELS_X = 2'd0,
        CFG_VOXELS_Y = 2'd1,
        CFG_VOXELS_Z = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                      opcode;
        logic [1:0]                axis;
        logic [BIDX_W-1:0]         bound_index;
        logic signed [COORD_W-1:0] bound_value;
        logic [REGION_W-1:0]       region;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [DIR_W-1:0]   dir_u;
        logic signed [DIR_W-1:0]   dir_v;
        logic signed [DIR_W-1:0]   dir_w;
        logic [DIST_W-1:0]         step_limit;
    } t_in_beat;

    typedef struct packed {
        logic                discard;
        logic [DIST_W-1:0]   step_length;
        logic [REGION_W-1:0] next_region;
        logic                boundary_hit;
        logic [DIST_W-1:0]   nearest_distance;
    } t_out_beat;

    // Beat plus the x index, carried through the second region divider.
    typedef struct packed {
        t_in_beat          beat;
        logic [CNT_W-1:0]  ix;
    } t_div_b_tag;

    // Per-axis face information carried alongside the face divider.
    typedef struct packed {
        logic                live;   // direction cosine is nonzero
        logic                ok;     // face lies ahead of the particle
        logic                sat;    // quotient exceeds the distance range
        logic [REGION_W-1:0] nbr;    // region beyond the face, 0 at the outer face
    } t_face_tag;

    typedef struct packed {
        logic                outside;
        logic [REGION_W-1:0] region;
        logic [DIST_W-1:0]   step_limit;
        logic [DIST_W-1:0]   near_dist;
    } t_common_tag;

    typedef struct packed {
        t_common_tag common;
        t_face_tag   face;
    } t_z_tag;

endpackage

### rtl/core/vgbd_div_pipe.sv
// ============================================================================
// Pipelined restoring divider
// One quotient bit per stage, a side tag travels with each operand.
// ============================================================================
module vgbd_div_pipe #(
    parameter int QW    = 19,
    parameter int DW    = 7,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [DW-1:0]    i_rem,
    input  logic [QW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [DW-1:0]    o_rem,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_valid [QW];
    logic [DW-1:0]    r_rem   [QW];
    logic [QW-1:0]    r_num   [QW];
    logic [DW-1:0]    r_den   [QW];
    logic [TAG_W-1:0] r_tag   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             s_valid;
        logic [DW-1:0]    s_rem;
        logic [QW-1:0]    s_num;
        logic [DW-1:0]    s_den;
        logic [TAG_W-1:0] s_tag;
        logic [DW:0]      s_trial;
        logic             s_fit;

        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_rem   = i_rem;
            assign s_num   = i_num;
            assign s_den   = i_den;
            assign s_tag   = i_tag;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_num   = r_num[k-1];
            assign s_den   = r_den[k-1];
            assign s_tag   = r_tag[k-1];
        end

        // The remainder stays below the divisor, so the trial fits DW+1 bits.
        assign s_trial = {s_rem, s_num[QW-1]};
        assign s_fit   = s_trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= s_fit ? DW'(s_trial - {1'b0, s_den}) : DW'(s_trial);
                r_num[k] <= {s_num[QW-2:0], s_fit};
                r_den[k] <= s_den;
                r_tag[k] <= s_tag;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_num[QW-1];
    assign o_rem   = r_rem[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

### rtl/core/vgbd_plane_mem.sv
// ============================================================================
// Plane coordinate table
// One write port and two registered read ports.
// ============================================================================
module vgbd_plane_mem #(
    parameter int DEPTH = 65,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/voxel_grid_boundary_distance.sv
// ============================================================================
// Voxel grid boundary distance
// Step limiting against the faces of a rectilinear voxel grid.
// ============================================================================
// Usage: beats arrive on the input channel (i_in_valid / o_in_ready). A load
// beat writes one plane coordinate into the x, y or z table and returns
// nothing. A query beat returns exactly one beat on the output channel
// (o_out_valid / i_out_ready) with the shortened step, the next region, the
// hit flag and the distance to the nearest face. Results leave in order.
// The voxel counts are set through the configuration channel, which is
// always ready; the user must write it only while the block holds no work,
// as the block itself does not enforce this. Throughput is one beat per
// cycle while the receiver does not stall. The edge that accepts a beat
// already loads the first of 72 pipeline registers: 19 for the x index divider,
// 19 for the y/z divider, one for the table read, one for the face setup, 31
// for the three face dividers running side by side, and the output register.
// A load writes its table as it leaves the y/z divider, ahead of every later
// query, so no forwarding is needed. When the receiver stalls, the whole
// pipeline freezes behind the full output register and o_in_ready drops.
// Reset empties the pipeline and sets all voxel counts to one; the plane
// tables are not cleared and must be loaded before use.
// ============================================================================
module voxel_grid_boundary_distance #(
    parameter int MAX_VOXELS_PER_AXIS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  vgbd_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vgbd_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vgbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vgbd_pkg::CNT_W-1:0]          i_cfg_data
);

    import vgbd_pkg::*;

    localparam int DEPTH = MAX_VOXELS_PER_AXIS + 1;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // A count of zero acts as one, a count above MAX_VOXELS_PER_AXIS as that max.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end
        if (32'(v) > MAX_VOXELS_PER_AXIS) begin
            return CNT_W'(MAX_VOXELS_PER_AXIS);
        end
        return v;
    endfunction

    function automatic t_diff smin(input t_diff a, input t_diff b);
        return (a < b) ? a : b;
    endfunction

    // Region beyond the face that the direction points at, 0 at the outer face.
    function automatic logic [REGION_W-1:0] nbr_region(
        input logic [REGION_W-1:0] reg_v,
        input logic [CNT_W-1:0]    idx,
        input logic [CNT_W-1:0]    n,
        input logic [REGION_W-1:0] stride,
        input logic                neg
    );
        if (neg) begin
            return (idx != '0) ? reg_v - stride : '0;
        end
        return (idx != n - CNT_W'(1)) ? reg_v + stride : '0;
    endfunction

    function automatic logic [DMAG_W-1:0] dir_mag(input logic signed [DIR_W-1:0] d);
        return d[DIR_W-1] ? DMAG_W'(-{d[DIR_W-1], d}) : DMAG_W'(d);
    endfunction

    function automatic logic [DIST_W-1:0] face_dist(
        input t_face_tag         f,
        input logic [DIST_W-1:0] quo
    );
        if (!f.ok) begin
            return '0;
        end
        return f.sat ? DIST_MAX : quo;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    r_voxels_x, r_voxels_y, r_voxels_z;
    logic [CNT_W-1:0]    nx, ny, nz;
    logic [STRIDE_W-1:0] r_nxy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxels_x <= CNT_W'(1);
            r_voxels_y <= CNT_W'(1);
            r_voxels_z <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_VOXELS_X: r_voxels_x <= i_cfg_data;
                CFG_VOXELS_Y: r_voxels_y <= i_cfg_data;
                CFG_VOXELS_Z: r_voxels_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nx = eff_count(r_voxels_x);
    assign ny = eff_count(r_voxels_y);
    assign nz = eff_count(r_voxels_z);

    // Stride of one z layer, registered from the effective x and y counts. It
    // settles long before a query can reach the stage that uses it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxy <= STRIDE_W'(1);
        end else begin
            r_nxy <= nx * ny;
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves unless a finished result is stuck.
    // ------------------------------------------------------------------
    logic      adv;
    t_out_beat r_out_data;
    logic      r_out_valid;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // ------------------------------------------------------------------
    // Region decode: r = region - 1, ix = r mod nx, then iy and iz from r / nx.
    // ------------------------------------------------------------------
    logic                a_valid;
    logic [REGION_W-1:0] a_quo;
    logic [CNT_W-1:0]    a_rem;
    t_in_beat            a_beat;

    vgbd_div_pipe #(
        .QW    (REGION_W),
        .DW    (CNT_W),
        .TAG_W ($bits(t_in_beat))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid && adv),
        .i_rem   ('0),
        .i_num   (i_in_data.region - REGION_W'(1)),
        .i_den   (nx),
        .i_tag   (i_in_data),
        .o_valid (a_valid),
        .o_quo   (a_quo),
        .o_rem   (a_rem),
        .o_tag   (a_beat)
    );

    logic                m_valid;
    logic [REGION_W-1:0] m_iz_full;
    logic [CNT_W-1:0]    m_iy;
    t_div_b_tag          a_tag, m_tag;

    assign a_tag.beat = a_beat;
    assign a_tag.ix   = a_rem;

    vgbd_div_pipe #(
        .QW    (REGION_W),
        .DW    (CNT_W),
        .TAG_W ($bits(t_div_b_tag))
    ) u_div_yz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (a_valid),
        .i_rem   ('0),
        .i_num   (a_quo),
        .i_den   (ny),
        .i_tag   (a_tag),
        .o_valid (m_valid),
        .o_quo   (m_iz_full),
        .o_rem   (m_iy),
        .o_tag   (m_tag)
    );

    // ------------------------------------------------------------------
    // Table access. Loads write here in program order; queries read both
    // faces of their voxel on every axis.
    // ------------------------------------------------------------------
    logic             m_outside;
    logic [CNT_W-1:0] m_iz;
    logic             m_load_ok;
    logic [AW-1:0]    m_waddr;
    logic             we_x, we_y, we_z;

    // Regions past the last voxel decode to a z index at or above nz.
    assign m_outside = (m_tag.beat.region == '0) || (m_iz_full >= REGION_W'(nz));
    assign m_iz      = m_outside ? '0 : m_iz_full[CNT_W-1:0];

    assign m_load_ok = m_valid && adv && (m_tag.beat.opcode == OP_LOAD)
                       && (32'(m_tag.beat.bound_index) <= MAX_VOXELS_PER_AXIS);
    assign m_waddr   = AW'(m_tag.beat.bound_index);
    assign we_x      = m_load_ok && (m_tag.beat.axis == AXIS_X);
    assign we_y      = m_load_ok && (m_tag.beat.axis == AXIS_Y);
    assign we_z      = m_load_ok && (m_tag.beat.axis == AXIS_Z);

    logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

    vgbd_plane_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COORD_W)) u_planes_x (
        .i_clk     (i_clk),
        .i_we      (we_x),
        .i_waddr   (m_waddr),
        .i_wdata   (m_tag.beat.bound_value),
        .i_re      (adv),
        .i_raddr_a (AW'(m_tag.ix)),
        .i_raddr_b (AW'(m_tag.ix + CNT_W'(1))),
        .o_rdata_a (x_lo),
        .o_rdata_b (x_hi)
    );

    vgbd_plane_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COORD_W)) u_planes_y (
        .i_clk     (i_clk),
        .i_we      (we_y),
        .i_waddr   (m_waddr),
        .i_wdata   (m_tag.beat.bound_value),
        .i_re      (adv),
        .i_raddr_a (AW'(m_iy)),
        .i_raddr_b (AW'(m_iy + CNT_W'(1))),
        .o_rdata_a (y_lo),
        .o_rdata_b (y_hi)
    );

    vgbd_plane_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COORD_W)) u_planes_z (
        .i_clk     (i_clk),
        .i_we      (we_z),
        .i_waddr   (m_waddr),
        .i_wdata   (m_tag.beat.bound_value),
        .i_re      (adv),
        .i_raddr_a (AW'(m_iz)),
        .i_raddr_b (AW'(m_iz + CNT_W'(1))),
        .o_rdata_a (z_lo),
        .o_rdata_b (z_hi)
    );

    // Read stage: only queries continue past the tables.
    logic             r_p_valid;
    t_in_beat         r_p_beat;
    logic             r_p_outside;
    logic [CNT_W-1:0] r_p_ix, r_p_iy, r_p_iz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= m_valid && (m_tag.beat.opcode == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_beat    <= m_tag.beat;
            r_p_outside <= m_outside;
            r_p_ix      <= m_tag.ix;
            r_p_iy      <= m_iy;
            r_p_iz      <= m_iz;
        end
    end

    // ------------------------------------------------------------------
    // Plane minus position on all six faces. The "lo" differences are taken
    // as position minus plane so that both are positive inside the voxel.
    // ------------------------------------------------------------------
    logic             r_g_valid;
    t_in_beat         r_g_beat;
    logic             r_g_outside;
    logic [CNT_W-1:0] r_g_ix, r_g_iy, r_g_iz;
    t_diff            r_g_dxh, r_g_dxl, r_g_dyh, r_g_dyl, r_g_dzh, r_g_dzl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (adv) begin
            r_g_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_beat    <= r_p_beat;
            r_g_outside <= r_p_outside;
            r_g_ix      <= r_p_ix;
            r_g_iy      <= r_p_iy;
            r_g_iz      <= r_p_iz;
            r_g_dxh     <= t_diff'($signed(x_hi)) - t_diff'(r_p_beat.pos_x);
            r_g_dxl     <= t_diff'(r_p_beat.pos_x) - t_diff'($signed(x_lo));
            r_g_dyh     <= t_diff'($signed(y_hi)) - t_diff'(r_p_beat.pos_y);
            r_g_dyl     <= t_diff'(r_p_beat.pos_y) - t_diff'($signed(y_lo));
            r_g_dzh     <= t_diff'($signed(z_hi)) - t_diff'(r_p_beat.pos_z);
            r_g_dzl     <= t_diff'(r_p_beat.pos_z) - t_diff'($signed(z_lo));
        end
    end

    // ------------------------------------------------------------------
    // Face setup. A face distance is |diff| * 2^14 / |dir|. The quotient
    // overflows 31 bits exactly when |diff| >> 17 reaches |dir|; otherwise
    // those top bits start the divider's remainder and the remaining
    // dividend bits are |diff|[16:0] followed by fourteen zeros.
    // ------------------------------------------------------------------
    t_diff            g_near_raw;
    logic [DIST_W-1:0] g_near;
    t_common_tag      g_common;
    t_face_tag        g_fx, g_fy, g_fz;
    logic [DMAG_W-1:0] g_mx, g_my, g_mz;
    t_diff            g_sx, g_sy, g_sz;
    t_z_tag           g_ztag;

    assign g_near_raw = smin(smin(smin(r_g_dxh, r_g_dxl), smin(r_g_dyh, r_g_dyl)),
                             smin(smin(r_g_dzh, r_g_dzl), t_diff'(DIST_MAX)));
    assign g_near     = g_near_raw[COORD_W] ? '0 : g_near_raw[DIST_W-1:0];

    assign g_mx = dir_mag(r_g_beat.dir_u);
    assign g_my = dir_mag(r_g_beat.dir_v);
    assign g_mz = dir_mag(r_g_beat.dir_w);

    // Moving toward -axis uses the lower face, whose "lo" difference is
    // positive exactly when the face is ahead.
    assign g_sx = r_g_beat.dir_u[DIR_W-1] ? r_g_dxl : r_g_dxh;
    assign g_sy = r_g_beat.dir_v[DIR_W-1] ? r_g_dyl : r_g_dyh;
    assign g_sz = r_g_beat.dir_w[DIR_W-1] ? r_g_dzl : r_g_dzh;

    always_comb begin
        g_fx.live = r_g_beat.dir_u != '0;
        g_fy.live = r_g_beat.dir_v != '0;
        g_fz.live = r_g_beat.dir_w != '0;
        g_fx.ok   = g_sx > 0;
        g_fy.ok   = g_sy > 0;
        g_fz.ok   = g_sz > 0;
        g_fx.sat  = DMAG_W'(g_sx[COORD_W-1:17]) >= g_mx;
        g_fy.sat  = DMAG_W'(g_sy[COORD_W-1:17]) >= g_my;
        g_fz.sat  = DMAG_W'(g_sz[COORD_W-1:17]) >= g_mz;
        g_fx.nbr  = nbr_region(r_g_beat.region, r_g_ix, nx, REGION_W'(1),
                               r_g_beat.dir_u[DIR_W-1]);
        g_fy.nbr  = nbr_region(r_g_beat.region, r_g_iy, ny, REGION_W'(nx),
                               r_g_beat.dir_v[DIR_W-1]);
        g_fz.nbr  = nbr_region(r_g_beat.region, r_g_iz, nz, REGION_W'(r_nxy),
                               r_g_beat.dir_w[DIR_W-1]);
    end

    assign g_common.outside    = r_g_outside;
    assign g_common.region     = r_g_beat.region;
    assign g_common.step_limit = r_g_beat.step_limit;
    assign g_common.near_dist  = g_near;
    assign g_ztag.common       = g_common;
    assign g_ztag.face         = g_fz;

    // ------------------------------------------------------------------
    // Face dividers, one per axis, in lockstep.
    // ------------------------------------------------------------------
    logic              c_valid;
    logic [DIST_W-1:0] c_qx, c_qy, c_qz;
    t_z_tag            c_ztag;
    t_face_tag         c_fx, c_fy;

    vgbd_div_pipe #(
        .QW    (DIST_W),
        .DW    (DMAG_W),
        .TAG_W ($bits(t_z_tag))
    ) u_div_face_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_g_valid),
        .i_rem   (DMAG_W'(g_sz[COORD_W-1:17])),
        .i_num   ({g_sz[16:0], 14'd0}),
        .i_den   (g_mz),
        .i_tag   (g_ztag),
        .o_valid (c_valid),
        .o_quo   (c_qz),
        .o_rem   (),
        .o_tag   (c_ztag)
    );

    vgbd_div_pipe #(
        .QW    (DIST_W),
        .DW    (DMAG_W),
        .TAG_W ($bits(t_face_tag))
    ) u_div_face_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_g_valid),
        .i_rem   (DMAG_W'(g_sx[COORD_W-1:17])),
        .i_num   ({g_sx[16:0], 14'd0}),
        .i_den   (g_mx),
        .i_tag   (g_fx),
        .o_valid (),
        .o_quo   (c_qx),
        .o_rem   (),
        .o_tag   (c_fx)
    );

    vgbd_div_pipe #(
        .QW    (DIST_W),
        .DW    (DMAG_W),
        .TAG_W ($bits(t_face_tag))
    ) u_div_face_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_g_valid),
        .i_rem   (DMAG_W'(g_sy[COORD_W-1:17])),
        .i_num   ({g_sy[16:0], 14'd0}),
        .i_den   (g_my),
        .i_tag   (g_fy),
        .o_valid (),
        .o_quo   (c_qy),
        .o_rem   (),
        .o_tag   (c_fy)
    );

    // ------------------------------------------------------------------
    // Step resolution in the order z, x, y. A face only cuts the step when
    // it is strictly closer, so earlier axes win ties.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]   e_dx, e_dy, e_dz, e_step;
    logic [REGION_W-1:0] e_next;
    logic                e_hit;
    t_out_beat           e_beat;

    assign e_dz = face_dist(c_ztag.face, c_qz);
    assign e_dx = face_dist(c_fx, c_qx);
    assign e_dy = face_dist(c_fy, c_qy);

    always_comb begin
        e_step = c_ztag.common.step_limit;
        e_next = c_ztag.common.region;
        e_hit  = 1'b0;
        if (c_ztag.face.live && (e_dz < e_step)) begin
            e_step = e_dz;
            e_next = c_ztag.face.nbr;
            e_hit  = 1'b1;
        end
        if (c_fx.live && (e_dx < e_step)) begin
            e_step = e_dx;
            e_next = c_fx.nbr;
            e_hit  = 1'b1;
        end
        if (c_fy.live && (e_dy < e_step)) begin
            e_step = e_dy;
            e_next = c_fy.nbr;
            e_hit  = 1'b1;
        end

        if (c_ztag.common.outside) begin
            e_beat.discard          = 1'b1;
            e_beat.step_length      = c_ztag.common.step_limit;
            e_beat.next_region      = c_ztag.common.region;
            e_beat.boundary_hit     = 1'b0;
            e_beat.nearest_distance = '0;
        end else begin
            e_beat.discard          = 1'b0;
            e_beat.step_length      = e_step;
            e_beat.next_region      = e_next;
            e_beat.boundary_hit     = e_hit;
            e_beat.nearest_distance = c_ztag.common.near_dist;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= e_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Voxel grid boundary distance testbench
// Loads plane tables, sends load and query beats with random gaps and output
// stalls, and checks every result against an in-bench step limiting predictor.
// ============================================================================
module tb;
    import vgbd_pkg::*;

    localparam int NMAX        = 64;
    localparam int DRAIN_WAIT  = 90;       // covers the full pipeline depth
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_beat    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_beat   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    voxel_grid_boundary_distance uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // The clock runs freely from time zero.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the block state: plane tables and raw voxel counts.
    logic signed [COORD_W-1:0] plane_tab [3][0:NMAX];
    logic [CNT_W-1:0]          count_reg [3];

    t_out_beat expected_steps[$];
    int        errors;
    int        queries_sent;
    int        loads_sent;
    int        results_seen;
    int        hits_seen;
    int        discards_seen;
    bit        no_idle;       // when set, neither side inserts gaps
    int        out_stall;
    longint    cycles;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A register value of 0 behaves as one voxel, values above 64 as 64.
    function automatic longint voxel_count(input logic [CNT_W-1:0] raw);
        if (raw < 1) return 1;
        if (raw > NMAX) return NMAX;
        return raw;
    endfunction

    // Distance along the ray to a plane, truncated and saturated. A plane
    // behind the particle or exactly under it gives zero.
    function automatic longint face_distance(input longint plane, input longint pos,
                                             input longint dir);
        longint diff;
        longint mdiff;
        longint mdir;
        longint q;
        diff = plane - pos;
        if (diff == 0 || ((diff < 0) != (dir < 0))) return 0;
        mdiff = (diff < 0) ? -diff : diff;
        mdir  = (dir < 0) ? -dir : dir;
        q = (mdiff <<< 14) / mdir;
        return (q > DIST_MAX) ? longint'(DIST_MAX) : q;
    endfunction

    function automatic longint clamp_dist(input longint d);
        if (d < 0) return 0;
        return (d > DIST_MAX) ? longint'(DIST_MAX) : d;
    endfunction

    // Checks the leaving face of one axis and shortens the step if it is
    // strictly closer than the step so far.
    task automatic cut_at_face(input int ax, input longint idx, input longint n,
                               input longint pos, input longint dir,
                               input longint region, input longint stride,
                               inout longint step, inout longint next_reg,
                               inout bit hit);
        longint d;
        if (dir == 0) return;
        if (dir > 0) begin
            d = face_distance(plane_tab[ax][idx + 1], pos, dir);
            if (d < step) begin
                step = d;
                hit = 1'b1;
                next_reg = (idx != n - 1) ? region + stride : 0;
            end
        end else begin
            d = face_distance(plane_tab[ax][idx], pos, dir);
            if (d < step) begin
                step = d;
                hit = 1'b1;
                next_reg = (idx != 0) ? region - stride : 0;
            end
        end
    endtask

    task automatic predict_step(input t_in_beat b, output t_out_beat r);
        longint nx, ny, nz, reg_no, rr, ix, iy, iz, step, next_reg, near;
        longint px, py, pz;
        bit hit;
        nx = voxel_count(count_reg[0]);
        ny = voxel_count(count_reg[1]);
        nz = voxel_count(count_reg[2]);
        reg_no = b.region;
        step = b.step_limit;
        r = '0;
        // Outside the geometry, or a region number beyond the grid.
        if (reg_no == 0 || reg_no - 1 >= nx * ny * nz) begin
            r.discard = 1'b1;
            r.step_length = b.step_limit;
            r.next_region = b.region;
            return;
        end
        rr = reg_no - 1;
        ix = rr % nx;
        iy = (rr / nx) % ny;
        iz = rr / (nx * ny);
        px = b.pos_x;
        py = b.pos_y;
        pz = b.pos_z;
        next_reg = reg_no;
        hit = 1'b0;
        // Faces are visited z first, then x, then y.
        cut_at_face(AXIS_Z, iz, nz, pz, longint'(b.dir_w), reg_no, nx * ny,
                    step, next_reg, hit);
        cut_at_face(AXIS_X, ix, nx, px, longint'(b.dir_u), reg_no, 1,
                    step, next_reg, hit);
        cut_at_face(AXIS_Y, iy, ny, py, longint'(b.dir_v), reg_no, nx,
                    step, next_reg, hit);
        near = DIST_MAX;
        near = (plane_tab[AXIS_X][ix + 1] - px < near) ? plane_tab[AXIS_X][ix + 1] - px : near;
        near = (px - plane_tab[AXIS_X][ix] < near) ? px - plane_tab[AXIS_X][ix] : near;
        near = (plane_tab[AXIS_Y][iy + 1] - py < near) ? plane_tab[AXIS_Y][iy + 1] - py : near;
        near = (py - plane_tab[AXIS_Y][iy] < near) ? py - plane_tab[AXIS_Y][iy] : near;
        near = (plane_tab[AXIS_Z][iz + 1] - pz < near) ? plane_tab[AXIS_Z][iz + 1] - pz : near;
        near = (pz - plane_tab[AXIS_Z][iz] < near) ? pz - plane_tab[AXIS_Z][iz] : near;
        r.step_length = DIST_W'(clamp_dist(step));
        r.next_region = next_reg[REGION_W-1:0];
        r.boundary_hit = hit;
        r.nearest_distance = DIST_W'(clamp_dist(near));
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Sends one beat. The caller is at a falling edge and so is the return.
    // Valid stays high across back-to-back beats.
    task automatic send_beat(input t_in_beat b);
        int gap;
        t_out_beat r;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (b.opcode == OP_QUERY) begin
            predict_step(b, r);
            expected_steps.push_back(r);
            queries_sent++;
        end else begin
            if (b.bound_index <= NMAX && b.axis != 2'd3)
                plane_tab[b.axis][b.bound_index] = b.bound_value;
            loads_sent++;
        end
        @(negedge clk);
    endtask

    task automatic idle_and_drain();
        in_valid = 1'b0;
        while (expected_steps.size() != 0) @(negedge clk);
        // Loads leave no trace, so give the pipeline time to empty.
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx <= CFG_VOXELS_Z) count_reg[idx] = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(input logic [CNT_W-1:0] vx, input logic [CNT_W-1:0] vy,
                            input logic [CNT_W-1:0] vz);
        idle_and_drain();
        write_count(CFG_VOXELS_X, vx);
        write_count(CFG_VOXELS_Y, vy);
        write_count(CFG_VOXELS_Z, vz);
    endtask

    function automatic t_in_beat load_beat(input int ax, input int idx, input logic [31:0] v);
        t_in_beat b;
        b = '0;
        b.opcode = OP_LOAD;
        b.axis = ax[1:0];
        b.bound_index = idx[BIDX_W-1:0];
        b.bound_value = v;
        return b;
    endfunction

    // Fills all 65 planes of each table with an evenly spaced grid.
    task automatic load_planes(input int spacing);
        longint base;
        for (int ax = 0; ax < 3; ax++) begin
            base = -longint'(32) * spacing + $urandom_range(0, 1000) - 500;
            for (int i = 0; i <= NMAX; i++)
                send_beat(load_beat(ax, i, 32'(base + longint'(i) * spacing)));
        end
    endtask

    function automatic logic signed [DIR_W-1:0] rand_cosine();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'($urandom);          // anything the field holds
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pos_in_voxel(input int ax, input longint idx);
        longint lo, hi;
        lo = plane_tab[ax][idx];
        hi = plane_tab[ax][idx + 1];
        if (hi <= lo) return $urandom;
        return 32'(lo + longint'($urandom) % (hi - lo + 1));
    endfunction

    // A well-formed query inside the grid, or with a small chance noise.
    function automatic t_in_beat query_beat();
        t_in_beat b;
        longint nx, ny, nz, ix, iy, iz;
        nx = voxel_count(count_reg[0]);
        ny = voxel_count(count_reg[1]);
        nz = voxel_count(count_reg[2]);
        b = '0;
        b.opcode = OP_QUERY;
        b.axis = 2'($urandom);
        b.bound_index = 7'($urandom);
        b.bound_value = $urandom;
        ix = $urandom_range(0, nx - 1);
        iy = $urandom_range(0, ny - 1);
        iz = $urandom_range(0, nz - 1);
        b.region = 19'(1 + ix + iy * nx + iz * nx * ny);
        b.pos_x = pos_in_voxel(AXIS_X, ix);
        b.pos_y = pos_in_voxel(AXIS_Y, iy);
        b.pos_z = pos_in_voxel(AXIS_Z, iz);
        b.dir_u = rand_cosine();
        b.dir_v = rand_cosine();
        b.dir_w = rand_cosine();
        case ($urandom_range(0, 5))
            0: b.step_limit = DIST_MAX;
            1: b.step_limit = 31'($urandom);
            2: b.step_limit = 31'($urandom_range(0, 1 << 12));
            default: b.step_limit = 31'($urandom_range(0, 1 << 22));
        endcase
        case ($urandom_range(0, 19))
            0: b.region = 19'($urandom);      // mostly beyond the grid
            1: b.region = '0;
            2: b.pos_x = $urandom;            // particle off its voxel
            3: b.pos_z = $urandom;
            default: ;
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, checking at the rising edge
    // ------------------------------------------------------------------------

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready = 1'b0;
        end else if (out_stall > 0 && !no_idle) begin
            out_ready = 1'b0;
            out_stall--;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        t_out_beat e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            out_stall = $urandom_range(0, 5);
            if (expected_steps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $realtime, out_data);
            end else begin
                e = expected_steps.pop_front();
                hits_seen += e.boundary_hit;
                discards_seen += e.discard;
                if (out_data.discard !== e.discard) begin
                    errors++;
                    $display("%0t: discard expected %0d got %0d", $realtime,
                             e.discard, out_data.discard);
                end
                if (out_data.step_length !== e.step_length) begin
                    errors++;
                    $display("%0t: step_length expected %0d got %0d", $realtime,
                             e.step_length, out_data.step_length);
                end
                if (out_data.next_region !== e.next_region) begin
                    errors++;
                    $display("%0t: next_region expected %0d got %0d", $realtime,
                             e.next_region, out_data.next_region);
                end
                if (out_data.boundary_hit !== e.boundary_hit) begin
                    errors++;
                    $display("%0t: boundary_hit expected %0d got %0d", $realtime,
                             e.boundary_hit, out_data.boundary_hit);
                end
                if (out_data.nearest_distance !== e.nearest_distance) begin
                    errors++;
                    $display("%0t: nearest_distance expected %0d got %0d", $realtime,
                             e.nearest_distance, out_data.nearest_distance);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_steps.size());
            $display("voxel_grid_boundary_distance: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset counts are one voxel per axis; query the single voxel.
    task automatic test_single_voxel();
        load_planes(1 << 16);
        for (int i = 0; i < 30; i++) send_beat(query_beat());
    endtask

    // Hand-picked corners: outside, beyond the grid, extreme fields,
    // ignored loads and an unknown register index.
    task automatic test_corner_cases();
        t_in_beat b;
        set_grid(7'd4, 7'd3, 7'd2);
        write_count(2'd3, 7'h7F);               // unknown index, no effect
        b = query_beat();
        b.region = '0;
        send_beat(b);                            // outside
        b = query_beat();
        b.region = 19'd25;
        send_beat(b);                            // first region past the grid
        b.region = {REGION_W{1'b1}};
        send_beat(b);
        b = query_beat();
        b.region = 19'd24;                       // last voxel, outer faces
        b.pos_x = plane_tab[AXIS_X][3] + 1;
        b.pos_y = plane_tab[AXIS_Y][2] + 1;
        b.pos_z = plane_tab[AXIS_Z][1] + 1;
        b.dir_u = 16'sd16384;
        b.dir_v = 16'sd0;
        b.dir_w = 16'sd0;
        b.step_limit = DIST_MAX;
        send_beat(b);
        b.dir_u = -16'sd16384;
        b.region = 19'd1;
        send_beat(b);                            // particle beyond its voxel
        b.dir_u = 16'sh8000;                     // most negative cosine
        send_beat(b);
        b.dir_u = '0;
        send_beat(b);                            // no direction at all
        b = query_beat();
        b.step_limit = '0;
        send_beat(b);
        b.pos_x = 32'sh7FFFFFFF;
        b.pos_y = 32'sh80000000;
        b.step_limit = DIST_MAX;
        send_beat(b);
        b = query_beat();
        b.region = 19'd1;
        b.pos_x = plane_tab[AXIS_X][0];          // exactly on a face
        b.dir_u = -16'sd1;
        send_beat(b);
        b.dir_u = 16'sd1;                        // tiny cosine, very long distance
        b.pos_x = plane_tab[AXIS_X][0];
        b.step_limit = DIST_MAX;
        send_beat(b);
        // Ignored loads: bad axis and indices past the table, then a harmless rewrite.
        send_beat(load_beat(3, 5, 32'hFFFFFFFF));
        send_beat(load_beat(AXIS_X, 65, 32'h0));
        send_beat(load_beat(AXIS_Z, 127, 32'h80000000));
        send_beat(load_beat(AXIS_Y, 64, plane_tab[AXIS_Y][64]));
        for (int i = 0; i < 6; i++) send_beat(query_beat());
    endtask

    // Register extremes: zero acts as one, above 64 acts as 64.
    task automatic test_count_extremes();
        set_grid(7'd0, 7'd127, 7'd65);
        for (int i = 0; i < 60; i++) send_beat(query_beat());
        set_grid(7'd64, 7'd64, 7'd64);
        load_planes(1 << 10);
        for (int i = 0; i < 80; i++) send_beat(query_beat());
    endtask

    // Random settings and a fresh plane spacing midway; back-to-back
    // stretches included.
    task automatic test_random_traffic();
        t_in_beat b;
        for (int ph = 0; ph < 8; ph++) begin
            set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(1, 20)),
                     7'($urandom_range(1, 64)));
            if (ph == 4) load_planes($urandom_range(1, 1 << 24));
            no_idle = (ph % 4 == 1);
            for (int i = 0; i < 20; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    // Rewrite one plane with anything, bad loads included.
                    b = load_beat($urandom_range(0, 3), $urandom_range(0, 127), $urandom);
                    send_beat(b);
                end else begin
                    send_beat(query_beat());
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        queries_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        discards_seen = 0;
        no_idle = 1'b0;
        out_stall = 0;
        cycles = 0;
        for (int ax = 0; ax < 3; ax++) begin
            count_reg[ax] = 7'd1;
            for (int i = 0; i <= NMAX; i++) plane_tab[ax][i] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_voxel();
        test_corner_cases();
        test_count_extremes();
        test_random_traffic();
        idle_and_drain();

        $display("covered %0d queries and %0d plane loads over several grid sizes",
                 queries_sent, loads_sent);
        $display("results checked %0d, face hits %0d, discards %0d",
                 results_seen, hits_seen, discards_seen);
        if (errors == 0 && expected_steps.size() == 0) begin
            $display("voxel_grid_boundary_distance: match");
        end else begin
            $display("voxel_grid_boundary_distance: mismatch");
        end
        $finish;
    end

endmodule
